[hdl/stroke_bounds_affine_aabb_defines.svh]
// Assertion macros used by the checker of the bounding box block.
`ifndef STROKE_BOUNDS_AFFINE_AABB_DEFINES_SVH
`define STROKE_BOUNDS_AFFINE_AABB_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBAA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbaa: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define SBAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbaa: next-cycle property violated");

`endif

[hdl/sbaa_pkg.sv]
// Types and constants of the transformed bounding box block.
package sbaa_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 24;
    localparam int WIDTH_W    = 16;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PAD_W  = COORD_W + 1;
    localparam int PROD_W = COEF_W + PAD_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int FRAC_W = 16;
    localparam int RND_W  = SUM_W - FRAC_W;

    localparam int PAD_Q8     = 512;
    localparam int ROUND_HALF = 32768;

    localparam logic signed [COORD_W-1:0] ACC_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] ACC_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEG  = 2'd0,
        REQ_BOX  = 2'd1,
        REQ_NONE = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX  = 3'd0,
        CFG_COEF_XY  = 3'd1,
        CFG_COEF_YX  = 3'd2,
        CFG_COEF_YY  = 3'd3,
        CFG_OFFSET_X = 3'd4,
        CFG_OFFSET_Y = 3'd5
    } t_cfg_idx;

endpackage

[hdl/stroke_bounds_affine_aabb.sv]
// Top level: streaming bounding box of one ink container mapped through an affine matrix.
//
// Input channel: i_valid with o_stall; one geometry element is transferred at a rising
// edge with i_valid high and o_stall low. Output channel: o_valid with i_stall; one world
// box is transferred at a rising edge with o_valid high and i_stall low.
// One element can be transferred every cycle while o_stall is low. Non-final elements
// give no result. The element marked last produces one result, which passes the input
// register, extent, fold into the running box, padding, products, rounded sums,
// saturation, then the min/max of the four corners into the output register.
// The eight corner multipliers are used once per result, so results also flow at one per
// cycle while i_stall is low. When the receiver stalls, results collect in the stages
// behind the output register and elements keep being taken until that chain is full;
// o_stall then rises. The user makes configuration writes on i_cfg_we while the block is
// idle; the block does not enforce it. A synchronous low i_rst_n empties every stage,
// loads the identity matrix and sets the running box to its empty value.
module stroke_bounds_affine_aabb #(
    parameter int COORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sbaa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sbaa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [sbaa_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [sbaa_pkg::COORD_W-1:0]   i_first_x,
    input  logic signed [sbaa_pkg::COORD_W-1:0]   i_first_y,
    input  logic signed [sbaa_pkg::COORD_W-1:0]   i_second_x,
    input  logic signed [sbaa_pkg::COORD_W-1:0]   i_second_y,
    input  logic [sbaa_pkg::WIDTH_W-1:0]          i_stroke_width,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [sbaa_pkg::COORD_W-1:0]   o_world_min_x,
    output logic signed [sbaa_pkg::COORD_W-1:0]   o_world_min_y,
    output logic signed [sbaa_pkg::COORD_W-1:0]   o_world_max_x,
    output logic signed [sbaa_pkg::COORD_W-1:0]   o_world_max_y,
    output logic                                  o_empty_res
);
    import sbaa_pkg::*;

    localparam int CW = (COORD_BITS > COORD_W) ? COORD_W : ((COORD_BITS < 2) ? 2 : COORD_BITS);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [PAD_W-1:0] PAD_V = PAD_W'(PAD_Q8);
    localparam logic signed [SUM_W-1:0] RND_V = SUM_W'(ROUND_HALF);

    typedef logic signed [COORD_W-1:0] t_coord;

    function automatic t_coord sat(input logic signed [63:0] v);
        t_coord r;
        if (v > SAT_HI) begin
            r = COORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = COORD_W'(SAT_LO);
        end else begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

    function automatic t_coord min2(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_coord max2(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic signed [COEF_W-1:0] r_cfg_xx, r_cfg_xy, r_cfg_yx, r_cfg_yy;
    t_coord                   r_cfg_ox, r_cfg_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_xx <= COEF_ONE;
            r_cfg_xy <= COEF_ZERO;
            r_cfg_yx <= COEF_ZERO;
            r_cfg_yy <= COEF_ONE;
            r_cfg_ox <= '0;
            r_cfg_oy <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_XX:  r_cfg_xx <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_XY:  r_cfg_xy <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_YX:  r_cfg_yx <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_YY:  r_cfg_yy <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_X: r_cfg_ox <= i_cfg_data[COORD_W-1:0];
                CFG_OFFSET_Y: r_cfg_oy <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers.
    logic                r_a_vld, r_a_last;
    logic [REQ_W-1:0]    r_a_type;
    t_coord              r_a_ax, r_a_ay, r_a_bx, r_a_by;
    logic [WIDTH_W-1:0]  r_a_w;

    logic                r_b_vld, r_b_last, r_b_geo;
    t_coord              r_b_lx, r_b_ly, r_b_hx, r_b_hy;

    t_coord              r_min_x, r_min_y, r_max_x, r_max_y;

    logic                r_c_vld;
    t_coord              r_c_lx, r_c_ly, r_c_hx, r_c_hy;

    logic                    r_d_vld, r_d_empty;
    logic signed [PAD_W-1:0] r_d_x [2];
    logic signed [PAD_W-1:0] r_d_y [2];

    logic                     r_e_vld, r_e_empty;
    logic signed [PROD_W-1:0] r_e_xx [2];
    logic signed [PROD_W-1:0] r_e_xy [2];
    logic signed [PROD_W-1:0] r_e_yx [2];
    logic signed [PROD_W-1:0] r_e_yy [2];

    logic                    r_f_vld, r_f_empty;
    logic signed [RND_W-1:0] r_f_wx [4];
    logic signed [RND_W-1:0] r_f_wy [4];

    logic   r_g_vld, r_g_empty;
    t_coord r_g_wx [4];
    t_coord r_g_wy [4];

    logic   r_o_vld, r_o_empty;
    t_coord r_o_min_x, r_o_min_y, r_o_max_x, r_o_max_y;

    // Ready chain: a stage takes new contents when it is empty or its contents move on.
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_o;
    logic fold_go;

    assign rdy_o   = !r_o_vld || !i_stall;
    assign rdy_g   = !r_g_vld || rdy_o;
    assign rdy_f   = !r_f_vld || rdy_g;
    assign rdy_e   = !r_e_vld || rdy_f;
    assign rdy_d   = !r_d_vld || rdy_e;
    assign rdy_c   = !r_c_vld || rdy_d;
    assign fold_go = r_b_vld && (!r_b_last || rdy_c);
    assign rdy_b   = !r_b_vld || fold_go;
    assign rdy_a   = !r_a_vld || rdy_b;
    assign o_stall = !rdy_a;

    // Element extent.
    logic [WIDTH_W:0]          w_half_sum;
    logic signed [63:0]        w_half;
    logic                      n_geo;
    t_coord                    n_lx, n_ly, n_hx, n_hy;

    always_comb begin
        w_half_sum = {1'b0, r_a_w} + (WIDTH_W+1)'(1);
        w_half     = 64'($signed({1'b0, w_half_sum[WIDTH_W:1]}));
        n_geo = 1'b0;
        n_lx  = '0;
        n_ly  = '0;
        n_hx  = '0;
        n_hy  = '0;
        case (t_req'(r_a_type))
            REQ_SEG: begin
                n_geo = 1'b1;
                n_lx  = min2(sat(64'(r_a_ax) - w_half), sat(64'(r_a_bx) - w_half));
                n_ly  = min2(sat(64'(r_a_ay) - w_half), sat(64'(r_a_by) - w_half));
                n_hx  = max2(sat(64'(r_a_ax) + w_half), sat(64'(r_a_bx) + w_half));
                n_hy  = max2(sat(64'(r_a_ay) + w_half), sat(64'(r_a_by) + w_half));
            end
            REQ_BOX: begin
                n_geo = 1'b1;
                n_lx  = sat(64'(r_a_ax));
                n_ly  = sat(64'(r_a_ay));
                n_hx  = sat(64'(r_a_bx));
                n_hy  = sat(64'(r_a_by));
            end
            default: n_geo = 1'b0;
        endcase
    end

    // Running box with the current element folded in.
    t_coord n_min_x, n_min_y, n_max_x, n_max_y;

    always_comb begin
        n_min_x = (r_b_geo && r_b_lx < r_min_x) ? r_b_lx : r_min_x;
        n_min_y = (r_b_geo && r_b_ly < r_min_y) ? r_b_ly : r_min_y;
        n_max_x = (r_b_geo && r_b_hx > r_max_x) ? r_b_hx : r_max_x;
        n_max_y = (r_b_geo && r_b_hy > r_max_y) ? r_b_hy : r_max_y;
    end

    // Corner minimum and maximum.
    t_coord n_o_min_x, n_o_min_y, n_o_max_x, n_o_max_y;

    always_comb begin
        n_o_min_x = min2(min2(r_g_wx[0], r_g_wx[1]), min2(r_g_wx[2], r_g_wx[3]));
        n_o_min_y = min2(min2(r_g_wy[0], r_g_wy[1]), min2(r_g_wy[2], r_g_wy[3]));
        n_o_max_x = max2(max2(r_g_wx[0], r_g_wx[1]), max2(r_g_wx[2], r_g_wx[3]));
        n_o_max_y = max2(max2(r_g_wy[0], r_g_wy[1]), max2(r_g_wy[2], r_g_wy[3]));
        if (r_g_empty) begin
            n_o_min_x = '0;
            n_o_min_y = '0;
            n_o_max_x = '0;
            n_o_max_y = '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_min_x <= ACC_POS;
            r_min_y <= ACC_POS;
            r_max_x <= ACC_NEG;
            r_max_y <= ACC_NEG;
        end else begin
            if (rdy_a) begin
                r_a_vld <= i_valid;
            end
            if (rdy_b) begin
                r_b_vld <= r_a_vld;
            end
            if (rdy_c) begin
                r_c_vld <= r_b_vld && r_b_last;
            end
            if (rdy_d) begin
                r_d_vld <= r_c_vld;
            end
            if (rdy_e) begin
                r_e_vld <= r_d_vld;
            end
            if (rdy_f) begin
                r_f_vld <= r_e_vld;
            end
            if (rdy_g) begin
                r_g_vld <= r_f_vld;
            end
            if (rdy_o) begin
                r_o_vld <= r_g_vld;
            end
            if (fold_go) begin
                if (r_b_last) begin
                    r_min_x <= ACC_POS;
                    r_min_y <= ACC_POS;
                    r_max_x <= ACC_NEG;
                    r_max_y <= ACC_NEG;
                end else begin
                    r_min_x <= n_min_x;
                    r_min_y <= n_min_y;
                    r_max_x <= n_max_x;
                    r_max_y <= n_max_y;
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_type <= i_req_type;
            r_a_ax   <= i_first_x;
            r_a_ay   <= i_first_y;
            r_a_bx   <= i_second_x;
            r_a_by   <= i_second_y;
            r_a_w    <= i_stroke_width;
            r_a_last <= i_last;
        end
        if (rdy_b && r_a_vld) begin
            r_b_geo  <= n_geo;
            r_b_lx   <= n_lx;
            r_b_ly   <= n_ly;
            r_b_hx   <= n_hx;
            r_b_hy   <= n_hy;
            r_b_last <= r_a_last;
        end
        if (rdy_c && r_b_vld && r_b_last) begin
            r_c_lx <= n_min_x;
            r_c_ly <= n_min_y;
            r_c_hx <= n_max_x;
            r_c_hy <= n_max_y;
        end
        if (rdy_d && r_c_vld) begin
            r_d_empty <= (r_c_lx > r_c_hx) || (r_c_ly > r_c_hy);
            r_d_x[0]  <= PAD_W'(r_c_lx) - PAD_V;
            r_d_x[1]  <= PAD_W'(r_c_hx) + PAD_V;
            r_d_y[0]  <= PAD_W'(r_c_ly) - PAD_V;
            r_d_y[1]  <= PAD_W'(r_c_hy) + PAD_V;
        end
        if (rdy_e && r_d_vld) begin
            r_e_empty <= r_d_empty;
            for (int i = 0; i < 2; i++) begin
                r_e_xx[i] <= PROD_W'(r_cfg_xx) * PROD_W'(r_d_x[i]);
                r_e_xy[i] <= PROD_W'(r_cfg_xy) * PROD_W'(r_d_x[i]);
                r_e_yx[i] <= PROD_W'(r_cfg_yx) * PROD_W'(r_d_y[i]);
                r_e_yy[i] <= PROD_W'(r_cfg_yy) * PROD_W'(r_d_y[i]);
            end
        end
        if (rdy_f && r_e_vld) begin
            r_f_empty <= r_e_empty;
            for (int i = 0; i < 4; i++) begin
                r_f_wx[i] <= RND_W'((SUM_W'(r_e_xx[i[0]]) + SUM_W'(r_e_yx[i[1]])
                             + (SUM_W'(r_cfg_ox) <<< FRAC_W) + RND_V) >>> FRAC_W);
                r_f_wy[i] <= RND_W'((SUM_W'(r_e_xy[i[0]]) + SUM_W'(r_e_yy[i[1]])
                             + (SUM_W'(r_cfg_oy) <<< FRAC_W) + RND_V) >>> FRAC_W);
            end
        end
        if (rdy_g && r_f_vld) begin
            r_g_empty <= r_f_empty;
            for (int i = 0; i < 4; i++) begin
                r_g_wx[i] <= sat(64'(r_f_wx[i]));
                r_g_wy[i] <= sat(64'(r_f_wy[i]));
            end
        end
        if (rdy_o && r_g_vld) begin
            r_o_empty <= r_g_empty;
            r_o_min_x <= n_o_min_x;
            r_o_min_y <= n_o_min_y;
            r_o_max_x <= n_o_max_x;
            r_o_max_y <= n_o_max_y;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_empty_res   = r_o_empty;
    assign o_world_min_x = r_o_min_x;
    assign o_world_min_y = r_o_min_y;
    assign o_world_max_x = r_o_max_x;
    assign o_world_max_y = r_o_max_y;

endmodule

[hdl/sbaa_checker.sv]
// Port-level checker for the bounding box block and its bind.
`include "stroke_bounds_affine_aabb_defines.svh"

module sbaa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_stall,
    input logic signed [sbaa_pkg::COORD_W-1:0] i_min_x,
    input logic signed [sbaa_pkg::COORD_W-1:0] i_min_y,
    input logic signed [sbaa_pkg::COORD_W-1:0] i_max_x,
    input logic signed [sbaa_pkg::COORD_W-1:0] i_max_y,
    input logic                                i_empty
);
    import sbaa_pkg::*;

    `SBAA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_min_x) && $stable(i_min_y) && $stable(i_max_x) && $stable(i_max_y) && $stable(i_empty))
    `SBAA_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_empty, i_min_x == '0 && i_min_y == '0 && i_max_x == '0 && i_max_y == '0)
    `SBAA_ASSERT_SAME(a_box_order, i_clk, i_rst_n, i_out_valid && !i_empty, i_min_x <= i_max_x && i_min_y <= i_max_y)
    `SBAA_ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid)

endmodule

bind stroke_bounds_affine_aabb sbaa_checker u_sbaa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_min_x     (o_world_min_x),
    .i_min_y     (o_world_min_y),
    .i_max_x     (o_world_max_x),
    .i_max_y     (o_world_max_y),
    .i_empty     (o_empty_res)
);
